// File: hw/rtl/fdl_pkg.sv
`timescale 1ns / 1ps
package fdl_pkg;

  localparam int DINT_W = 13;
  localparam int FRAC_W = 16;
  localparam int CFG_W  = 16;
  localparam int CFG_AW = 1;

  localparam logic [CFG_AW-1:0] REG_DELAY_INT  = 1'b0;
  localparam logic [CFG_AW-1:0] REG_DELAY_FRAC = 1'b1;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_RD,
    S_MUL,
    S_FIN
  } state_t;

  typedef struct packed {
    logic ld_tap;
    logic ld_prod;
  } interp_ctrl_t;

endpackage

// File: hw/rtl/fdl_ram.sv
`timescale 1ns / 1ps
module fdl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata0_r;
  logic [WIDTH-1:0] rdata1_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0_r <= mem[raddr0];
    rdata1_r <= mem[raddr1];
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

// File: hw/rtl/fdl_interp.sv
`timescale 1ns / 1ps
module fdl_interp #(
  parameter int SW = 24
) (
  input  logic                     clk,
  input  fdl_pkg::interp_ctrl_t    ctrl,
  input  logic [SW-1:0]            rd0,
  input  logic [SW-1:0]            rd1,
  input  logic [fdl_pkg::FRAC_W-1:0] frac,
  input  logic                     zero,
  output logic [SW-1:0]            res
);
  import fdl_pkg::*;

  logic signed [SW-1:0]  s0_r;
  logic signed [SW:0]    diff_r;
  logic signed [SW+17:0] prod_r;
  logic signed [SW+1:0]  sh;
  logic signed [SW+1:0]  sum;

  always_ff @(posedge clk) begin
    if (ctrl.ld_tap) begin
      s0_r   <= $signed(rd0);
      diff_r <= $signed({rd1[SW-1], rd1}) - $signed({rd0[SW-1], rd0});
    end
    if (ctrl.ld_prod) begin
      prod_r <= diff_r * $signed({1'b0, frac});
    end
  end

  // floor((s1 - s0) * frac / 2^16)
  assign sh  = prod_r[SW+17:16];
  assign sum = $signed({{2{s0_r[SW-1]}}, s0_r}) + sh;
  assign res = zero ? '0 : sum[SW-1:0];

endmodule

// File: hw/rtl/fractional_delay_line.sv
`timescale 1ns / 1ps
// Sample transaction: S_RD captures the taps and writes the sample, S_MUL registers the product
// and S_FIN registers the result once the output register is free; one sample at a time.
// Clear transaction: zero result from S_FIN, then a zeroing sweep of the single sample memory.
// Reset (rst_n low, synchronous) zeroes the write pointer and delay registers and starts the
// same sweep; no input is accepted during a sweep, config writes are.
module fractional_delay_line #(
  parameter int DEPTH        = 4096,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]          in_tdata,   // sample_in
  input  logic                                       in_tuser,   // opcode
  output logic                                       out_tvalid,
  input  logic                                       out_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]          out_tdata,  // sample_out
  input  logic                                       cfg_wen,
  input  logic [fdl_pkg::CFG_AW-1:0]                 cfg_addr,
  input  logic [fdl_pkg::CFG_W-1:0]                  cfg_wdata
);
  import fdl_pkg::*;

  localparam int SW  = SAMPLE_WIDTH;
  localparam int TDW = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = (AW + 1 > DINT_W) ? AW + 1 : DINT_W;
  localparam int PW  = CW + 1;

  state_t state_r, state_nxt;

  logic [AW-1:0]     wr_r;
  logic [AW-1:0]     clr_cnt_r;
  logic [DINT_W-1:0] dint_r;
  logic [FRAC_W-1:0] dfrac_r;
  logic [SW-1:0]     samp_r;
  logic [FRAC_W-1:0] f_r;
  logic              z_r;
  logic              clr_pend_r;
  logic [SW-1:0]     out_r;
  logic              out_vld_r;

  logic              acc;
  logic              fin_go;
  logic [CW-1:0]     dint_x;
  logic [CW-1:0]     d;
  logic [FRAC_W-1:0] f;
  logic [PW-1:0]     t0;
  logic [PW-1:0]     t1;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [SW-1:0]     ram_wdata;
  logic [SW-1:0]     rd0;
  logic [SW-1:0]     rd1;
  logic [SW-1:0]     res;
  interp_ctrl_t      ictrl;

  assign acc    = in_tvalid && in_tready;
  assign fin_go = !out_vld_r || out_tready;

  // effective delay and fraction
  always_comb begin
    dint_x = CW'(dint_r);
    if (dfrac_r == '0) begin
      d = (dint_x > CW'(DEPTH)) ? CW'(DEPTH) : dint_x;
      f = '0;
    end else if (dint_x == '0) begin
      d = CW'(1);
      f = '0;
    end else if (dint_x >= CW'(DEPTH - 1)) begin
      d = CW'(DEPTH - 1);
      f = '0;
    end else begin
      d = dint_x;
      f = dfrac_r;
    end
  end

  // tap addresses, wrapped at DEPTH
  always_comb begin
    t0 = PW'(wr_r) - PW'(d);
    if (t0[PW-1]) begin
      t0 = t0 + PW'(DEPTH);
    end
    t1 = PW'(wr_r) - PW'(d) - PW'(1);
    if (t1[PW-1]) begin
      t1 = t1 + PW'(DEPTH);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        if (clr_cnt_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (acc) state_nxt = (in_tuser == OP_CLEAR) ? S_FIN : S_RD;
      end
      S_RD:  state_nxt = S_MUL;
      S_MUL: state_nxt = S_FIN;
      S_FIN: begin
        if (fin_go) state_nxt = clr_pend_r ? S_CLR : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = wr_r;
    ram_wdata     = samp_r;
    ictrl.ld_tap  = 1'b0;
    ictrl.ld_prod = 1'b0;
    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      S_IDLE: in_tready = 1'b1;
      S_RD: begin
        ram_we       = 1'b1;
        ictrl.ld_tap = 1'b1;
      end
      S_MUL: ictrl.ld_prod = 1'b1;
      S_FIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      wr_r       <= '0;
      clr_cnt_r  <= '0;
      dint_r     <= '0;
      dfrac_r    <= '0;
      clr_pend_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wen) begin
        case (cfg_addr)
          REG_DELAY_INT:  dint_r  <= cfg_wdata[DINT_W-1:0];
          REG_DELAY_FRAC: dfrac_r <= cfg_wdata[FRAC_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_CLR) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end else begin
        clr_cnt_r <= '0;
      end
      if (acc) begin
        clr_pend_r <= (in_tuser == OP_CLEAR);
        if (in_tuser == OP_CLEAR) wr_r <= '0;
      end else if (state_r == S_RD) begin
        wr_r <= (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
      end
      if (state_r == S_FIN && fin_go) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      samp_r <= in_tdata[SW-1:0];
      f_r    <= f;
      z_r    <= (d == '0) || (in_tuser == OP_CLEAR);
    end
    if (state_r == S_FIN && fin_go) begin
      out_r <= res;
    end
  end

  fdl_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr0 (t0[AW-1:0]),
    .raddr1 (t1[AW-1:0]),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  fdl_interp #(
    .SW (SW)
  ) u_interp (
    .clk  (clk),
    .ctrl (ictrl),
    .rd0  (rd0),
    .rd1  (rd1),
    .frac (f_r),
    .zero (z_r),
    .res  (res)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = TDW'(out_r);

`ifndef ASSERT_OFF
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> !in_tready)
    else $error("transaction accepted while previous one in flight");

  a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (ram_waddr < AW'(DEPTH - 1)) || (ram_waddr == AW'(DEPTH - 1)))
    else $error("memory write address beyond depth");

  a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && fin_go && clr_pend_r) |=> (state_r == S_CLR && clr_cnt_r == '0))
    else $error("clear transaction did not start a sweep at entry zero");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && !fin_go) |=> state_r == S_FIN)
    else $error("result dropped while output register full");
`endif

endmodule
